// ----- rtl/cmsi_pkg.sv -----
package cmsi_pkg;

    localparam int GRID   = 15;
    localparam int DIR_W  = 16;
    localparam int FACE_W = 3;
    // Quotient bits needed to hold 0..GRID.
    localparam int Q_W    = $clog2(GRID + 1);
    // Divisor 2*max reaches 2^16, so it needs 17 bits.
    localparam int DIV_W  = DIR_W + 1;
    // Remainder stays below 2^Q_W * divisor.
    localparam int REM_W  = Q_W + DIV_W - 1;

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    localparam logic [Q_W-1:0] IDX_MAX = Q_W'(GRID - 1);

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              degenerate;
        logic [DIV_W-1:0]  div;
        logic [REM_W-1:0]  rem_u;
        logic [REM_W-1:0]  rem_v;
        logic [Q_W-1:0]    q_u;
        logic [Q_W-1:0]    q_v;
    } t_cell_data;

endpackage

// ----- rtl/cmsi_front.sv -----
module cmsi_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cmsi_pkg::DIR_W-1:0]   i_dir_x,
    input  logic signed [cmsi_pkg::DIR_W-1:0]   i_dir_y,
    input  logic signed [cmsi_pkg::DIR_W-1:0]   i_dir_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output cmsi_pkg::t_cell_data                o_data
);
    import cmsi_pkg::*;

    logic [DIR_W:0]    ax, ay, az, m;
    logic [DIR_W-1:0]  lead, cu, cv;
    logic [FACE_W-1:0] face_base, face;
    logic              zero;
    logic [DIR_W+1:0]  sum_u, sum_v;
    t_cell_data        n_data;
    logic              r_valid;
    t_cell_data        r_data;
    logic              advance;

    function automatic logic [DIR_W:0] abs_val(input logic [DIR_W-1:0] v);
        logic [DIR_W:0] s;
        s = {v[DIR_W-1], v};
        return s[DIR_W] ? (~s + 1'b1) : s;
    endfunction

    always_comb begin
        ax = abs_val(i_dir_x);
        ay = abs_val(i_dir_y);
        az = abs_val(i_dir_z);
        zero = (ax == '0) && (ay == '0) && (az == '0);
        // Settle ties x before y before z.
        if (ax >= ay && ax >= az) begin
            m = ax; lead = i_dir_x; face_base = FACE_PX; cu = i_dir_y; cv = i_dir_z;
        end else if (ay >= az) begin
            m = ay; lead = i_dir_y; face_base = FACE_PY; cu = i_dir_x; cv = i_dir_z;
        end else begin
            m = az; lead = i_dir_z; face_base = FACE_PZ; cu = i_dir_x; cv = i_dir_y;
        end
        face = face_base | FACE_W'(lead[DIR_W-1]);
        // c + m is never negative; keep the low bits.
        sum_u = {{2{cu[DIR_W-1]}}, cu} + {1'b0, m};
        sum_v = {{2{cv[DIR_W-1]}}, cv} + {1'b0, m};

        n_data.face       = zero ? FACE_PX : face;
        n_data.degenerate = zero;
        n_data.div        = {m[DIR_W-1:0], 1'b0};
        n_data.rem_u      = REM_W'(sum_u[DIR_W:0]) * REM_W'(GRID);
        n_data.rem_v      = REM_W'(sum_v[DIR_W:0]) * REM_W'(GRID);
        n_data.q_u        = '0;
        n_data.q_v        = '0;
    end

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/cmsi_div_cell.sv -----
module cmsi_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  cmsi_pkg::t_cell_data  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cmsi_pkg::t_cell_data  o_data
);
    import cmsi_pkg::*;

    logic [REM_W-1:0] div_top;
    logic             take_u, take_v;
    logic [REM_W-1:0] diff_u, diff_v;
    t_cell_data       n_data;
    logic             r_valid;
    t_cell_data       r_data;
    logic             advance;

    // One restoring step per lane: compare against the divisor at the top
    // quotient position, subtract on a hit, then shift the remainder up.
    always_comb begin
        div_top = {i_data.div, {(Q_W - 1){1'b0}}};
        take_u  = i_data.rem_u >= div_top;
        take_v  = i_data.rem_v >= div_top;
        diff_u  = take_u ? (i_data.rem_u - div_top) : i_data.rem_u;
        diff_v  = take_v ? (i_data.rem_v - div_top) : i_data.rem_v;

        n_data       = i_data;
        n_data.rem_u = {diff_u[REM_W-2:0], 1'b0};
        n_data.rem_v = {diff_v[REM_W-2:0], 1'b0};
        n_data.q_u   = {i_data.q_u[Q_W-2:0], take_u};
        n_data.q_v   = {i_data.q_v[Q_W-2:0], take_v};
    end

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/cube_map_sector_index.sv -----
// Cube map face and grid index lookup.
//
// Input channel: i_valid / o_ready with the direction vector on i_dir_x,
// i_dir_y and i_dir_z (signed, one common scale). Output channel:
// o_valid / i_ready with o_face, o_index_u, o_index_v and o_degenerate.
// A transfer happens on a rising edge with valid and ready both high.
//
// The front cell picks the face of the largest magnitude (ties go x, then
// y, then z) and forms GRID*(c+max) for the two other components. A chain
// of Q_W identical divide cells then resolves one quotient bit per cycle,
// unless held by a stall, against the divisor 2*max, both lanes side by
// side. The last cell's register is the output register; the clamp to
// GRID-1 sits behind it.
// An item passes the front register, then the Q_W cell registers, and one
// transfer is taken every cycle while the receiver does not stall. Each cell
// advances when it is empty or its successor takes its data, so a stalled
// receiver only holds the filled cells while empty cells upstream keep
// accepting. Reset empties every cell; no item is in flight afterwards. An
// all-zero vector gives face 0, indices 0 and o_degenerate high.
module cube_map_sector_index (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cmsi_pkg::DIR_W-1:0]   i_dir_x,
    input  logic signed [cmsi_pkg::DIR_W-1:0]   i_dir_y,
    input  logic signed [cmsi_pkg::DIR_W-1:0]   i_dir_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [cmsi_pkg::FACE_W-1:0]         o_face,
    output logic [cmsi_pkg::Q_W-1:0]            o_index_u,
    output logic [cmsi_pkg::Q_W-1:0]            o_index_v,
    output logic                                o_degenerate
);
    import cmsi_pkg::*;

    // Handshake and data between neighboring cells; entry 0 is the front.
    logic       valid_c [Q_W+1];
    logic       ready_c [Q_W+1];
    t_cell_data data_c  [Q_W+1];
    t_cell_data last;

    cmsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .o_valid (valid_c[0]),
        .i_ready (ready_c[0]),
        .o_data  (data_c[0])
    );

    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        cmsi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_c[k]),
            .o_ready (ready_c[k]),
            .i_data  (data_c[k]),
            .o_valid (valid_c[k+1]),
            .i_ready (ready_c[k+1]),
            .o_data  (data_c[k+1])
        );
    end

    assign ready_c[Q_W] = i_ready;
    assign last         = data_c[Q_W];
    assign o_valid      = valid_c[Q_W];

    // Clamp a component at plus the maximum down to the last column/row;
    // force zero indices for the all-zero vector.
    always_comb begin
        o_face       = last.face;
        o_degenerate = last.degenerate;
        if (last.degenerate) begin
            o_index_u = '0;
            o_index_v = '0;
        end else begin
            o_index_u = (last.q_u > IDX_MAX) ? IDX_MAX : last.q_u;
            o_index_v = (last.q_v > IDX_MAX) ? IDX_MAX : last.q_v;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_face <= FACE_NZ))
        else $error("face code out of range");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_index_u <= IDX_MAX && o_index_v <= IDX_MAX))
        else $error("grid index beyond clamp");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_face == FACE_PX && o_index_u == '0 && o_index_v == '0))
        else $error("degenerate result carries nonzero fields");

    a_pipe_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !valid_c[0] |-> o_ready)
        else $error("front cell empty but input not ready");

endmodule

// ----- tb/tb_cube_map_sector_index.sv -----
`timescale 1ns / 1ps

// Testbench for the cube map face and grid index lookup.
//
// Each direction vector sent is run through a local integer model of the
// lookup: pick the face of the largest magnitude (ties go x, then y,
// then z), then form floor(GRID*(c+max)/(2*max)) for the two other
// components and clamp it to GRID-1. The expected lookups wait in a queue
// in transfer order. Each output transfer is checked against the oldest
// entry.
//
// Both sides draw a random hold-off for every item. Some stretches run
// with no hold-off at all, and one phase drains the pipe before it goes on.
module tb_cube_map_sector_index;

    import cmsi_pkg::*;

    localparam int  RESET_CYCLES = 7;
    localparam int  PIPE_LATENCY = 1 + Q_W;
    // Watchdog bound for a run of about 600 items with random hold-offs on both sides.
    localparam int  CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic [Q_W-1:0]    index_u;
        logic [Q_W-1:0]    index_v;
        logic              degenerate;
    } t_lookup;

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    i_valid  = 1'b0;
    logic                    o_ready;
    logic signed [DIR_W-1:0] i_dir_x  = '0;
    logic signed [DIR_W-1:0] i_dir_y  = '0;
    logic signed [DIR_W-1:0] i_dir_z  = '0;
    logic                    o_valid;
    logic                    i_ready  = 1'b0;
    logic [FACE_W-1:0]       o_face;
    logic [Q_W-1:0]          o_index_u;
    logic [Q_W-1:0]          o_index_v;
    logic                    o_degenerate;

    t_lookup expected_lookups[$];
    int      error_count = 0;
    int      cycle_count = 0;
    // While set, neither side holds off.
    bit      no_idle     = 1'b0;

    cube_map_sector_index u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_dir_z      (i_dir_z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_face       (o_face),
        .o_index_u    (o_index_u),
        .o_index_v    (o_index_v),
        .o_degenerate (o_degenerate)
    );

    always #4 i_clk = ~i_clk;

    // Grid index on the face: exact floor, then clamp to GRID-1.
    function automatic logic [Q_W-1:0] texel_of(longint comp, longint peak);
        longint q;
        q = (longint'(GRID) * (comp + peak)) / (2 * peak);
        if (q > GRID - 1) begin
            q = GRID - 1;
        end
        return q[Q_W-1:0];
    endfunction

    function automatic t_lookup predict_lookup(logic signed [DIR_W-1:0] x,
                                               logic signed [DIR_W-1:0] y,
                                               logic signed [DIR_W-1:0] z);
        t_lookup r;
        longint  sx, sy, sz, ax, ay, az, peak;
        sx = x;
        sy = y;
        sz = z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        r = '0;
        if (ax == 0 && ay == 0 && az == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        // Settle magnitude ties x first, then y, then z.
        if (ax >= ay && ax >= az) begin
            peak      = ax;
            r.face    = (sx < 0) ? FACE_NX : FACE_PX;
            r.index_u = texel_of(sy, peak);
            r.index_v = texel_of(sz, peak);
        end else if (ay >= az) begin
            peak      = ay;
            r.face    = (sy < 0) ? FACE_NY : FACE_PY;
            r.index_u = texel_of(sx, peak);
            r.index_v = texel_of(sz, peak);
        end else begin
            peak      = az;
            r.face    = (sz < 0) ? FACE_NZ : FACE_PZ;
            r.index_u = texel_of(sx, peak);
            r.index_v = texel_of(sy, peak);
        end
        return r;
    endfunction

    function automatic int pick_wait();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Apply a random sign; magnitude 32768 exists only as a negative value.
    function automatic int signed_of(int magn);
        if (magn >= 32768 || $urandom_range(0, 1) == 1) begin
            return -magn;
        end
        return magn;
    endfunction

    // Random value in [-peak, peak] that still fits 16 bits.
    function automatic int bounded_by(int peak);
        int v;
        case ($urandom_range(0, 5))
            0: v = peak;
            1: v = -peak;
            2: v = 0;
            default: v = int'($urandom_range(0, 2 * peak)) - peak;
        endcase
        if (v > 32767) begin
            v = 32767;
        end
        return v;
    endfunction

    // Drive one direction at the falling edge and hold it until the transfer.
    task automatic send_dir(input int x, input int y, input int z);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_dir_x <= DIR_W'(x);
        i_dir_y <= DIR_W'(y);
        i_dir_z <= DIR_W'(z);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_lookups.insert(expected_lookups.size(),
                                predict_lookup(DIR_W'(x), DIR_W'(y), DIR_W'(z)));
    endtask

    // Draw one direction from a mix of shapes: uniform words, tiny values,
    // magnitude ties, and one leading component with the others bounded.
    task automatic send_random_dir();
        int c[3];
        int peak;
        int lead;
        int rot;
        case ($urandom_range(0, 9))
            0, 1: begin
                c[0] = int'($signed($urandom_range(0, 65535) - 32768));
                c[1] = int'($signed($urandom_range(0, 65535) - 32768));
                c[2] = int'($signed($urandom_range(0, 65535) - 32768));
            end
            2: begin
                c[0] = int'($urandom_range(0, 6)) - 3;
                c[1] = int'($urandom_range(0, 6)) - 3;
                c[2] = int'($urandom_range(0, 6)) - 3;
            end
            3, 4: begin
                peak = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(1, 32767);
                c[0] = signed_of(peak);
                c[1] = signed_of(peak);
                c[2] = ($urandom_range(0, 2) == 0) ? signed_of(peak) : bounded_by(peak);
            end
            default: begin
                peak = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(1, 32767);
                if (peak > 32767) begin
                    c[0] = -32768;
                end else begin
                    c[0] = signed_of(peak);
                end
                c[1] = bounded_by(peak);
                c[2] = bounded_by(peak);
            end
        endcase
        // Rotate so every shape lands on every axis.
        rot = $urandom_range(0, 2);
        lead = c[rot];
        send_dir(lead, c[(rot + 1) % 3], c[(rot + 2) % 3]);
    endtask

    task automatic test_directed();
        send_dir(0, 0, 0);                     // all-zero vector
        send_dir(32767, 0, 0);
        send_dir(-32768, 0, 0);                // most negative component
        send_dir(0, 32767, 0);
        send_dir(0, -32768, 0);
        send_dir(0, 0, 32767);
        send_dir(0, 0, -32768);
        send_dir(100, 100, 100);               // three-way tie, plus the max
        send_dir(-5, 5, 5);
        send_dir(5, -5, 5);
        send_dir(0, 7, -7);                    // y and z tie
        send_dir(-9, 9, 0);                    // x and y tie
        send_dir(-32768, 32767, -32768);
        send_dir(-32768, -32768, -32768);
        send_dir(32767, -32768, 0);
        send_dir(32767, 32767, 32767);
        send_dir(1, 0, 0);
        send_dir(0, 0, -1);
        send_dir(-1, 1, -1);
        send_dir(12345, -6789, 100);
        send_dir(-300, 2999, -3000);
        send_dir(-21846, 10923, 32767);
    endtask

    task automatic test_random_mixed(input int count);
        repeat (count) send_random_dir();
    endtask

    // Hold the sender until the pipe has fully drained, then go on.
    task automatic test_drain_pause();
        repeat (30) send_random_dir();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
        repeat (30) send_random_dir();
    endtask

    // Alternate full-rate stretches with idling ones.
    task automatic test_random_bursts(input int rounds);
        repeat (rounds) begin
            no_idle = 1'b1;
            repeat ($urandom_range(20, 40)) send_random_dir();
            no_idle = 1'b0;
            repeat ($urandom_range(10, 30)) send_random_dir();
        end
    endtask

    // Receiver: draw a stall before each result, then take it.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = pick_wait();
            if (stall > 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Check every output transfer against the oldest expected lookup.
    always @(posedge i_clk) begin
        t_lookup want;
        t_lookup got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_face, o_index_u, o_index_v, o_degenerate};
            if (expected_lookups.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transfer face %0d u %0d v %0d degenerate %0d",
                         $time, got.face, got.index_u, got.index_v, got.degenerate);
            end else begin
                want = expected_lookups.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected face %0d u %0d v %0d degenerate %0d",
                             $time, want.face, want.index_u, want.index_v,
                             want.degenerate);
                    $display("%0t:          actual   face %0d u %0d v %0d degenerate %0d",
                             $time, got.face, got.index_u, got.index_v, got.degenerate);
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mixed(268);
        test_drain_pause();
        test_random_bursts(4);

        // Drop valid, drain what is in flight, then let the pipe idle before the verdict.
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
